// ----- hw/rtl/assert_macros.svh -----
// Assertion helpers shared by the RTL. Each checks on the rising edge of i_clk
// and is switched off while the synchronous reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A plain condition that must hold at every clock edge out of reset.
`define NAT_ASSERT(lbl, cond, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (cond)) else $error(msg);

// An implication checked in the same cycle.
`define NAT_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

`endif

// ----- hw/rtl/nat_pkg.sv -----
package nat_pkg;

    localparam int NODE_SLOTS = 16;
    localparam int IDX_W      = (NODE_SLOTS > 1) ? $clog2(NODE_SLOTS) : 1;
    localparam int CNT_W      = $clog2(NODE_SLOTS + 1);
    localparam int NODE_W     = 8;
    localparam int ADDR_W     = 160;
    localparam int TIME_W     = 32;
    localparam int COUNT_W    = 5;

    localparam logic [1:0] OP_REMEMBER     = 2'd0;
    localparam logic [1:0] OP_ADDR_BY_NODE = 2'd1;
    localparam logic [1:0] OP_NODE_BY_ADDR = 2'd2;
    localparam logic [1:0] OP_UNUSED       = 2'd3;

    localparam logic [2:0] ST_UPDATED  = 3'd0;
    localparam logic [2:0] ST_INSERTED = 3'd1;
    localparam logic [2:0] ST_IGNORED  = 3'd2;
    localparam logic [2:0] ST_FULL     = 3'd3;
    localparam logic [2:0] ST_HIT      = 3'd4;
    localparam logic [2:0] ST_MISS     = 3'd5;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_FIN
    } t_state;

    typedef struct packed {
        logic [1:0]        opcode;
        logic [NODE_W-1:0] node_id;
        logic [63:0]       key_high;
        logic [63:0]       key_mid;
        logic [31:0]       key_low;
        logic              key_valid;
        logic [TIME_W-1:0] now_ms;
    } t_in_item;

    typedef struct packed {
        logic [2:0]         status;
        logic [NODE_W-1:0]  node_out;
        logic [63:0]        addr_out_high;
        logic [63:0]        addr_out_mid;
        logic [31:0]        addr_out_low;
        logic [COUNT_W-1:0] known_count;
    } t_out_item;

    // One slot of the table as held in memory.
    typedef struct packed {
        logic [NODE_W-1:0] node;
        logic [ADDR_W-1:0] addr;
        logic [TIME_W-1:0] seen;
    } t_entry;

    // What the scan unit hands back to the controller.
    typedef struct packed {
        logic              done;
        logic              hit;
        logic [IDX_W-1:0]  hit_idx;
        logic [NODE_W-1:0] hit_node;
        logic [ADDR_W-1:0] hit_addr;
        logic              free;
        logic [IDX_W-1:0]  free_idx;
    } t_scan_res;

endpackage

// ----- hw/rtl/nat_ram.sv -----
module nat_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_we,
    input  logic [AW-1:0]    i_waddr,
    input  logic [WIDTH-1:0] i_wdata,
    input  logic [AW-1:0]    i_raddr,
    output logic [WIDTH-1:0] o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ----- hw/rtl/nat_scan.sv -----
module nat_scan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_start,
    input  logic [1:0]                     i_op,
    input  logic [nat_pkg::NODE_W-1:0]     i_node,
    input  logic [nat_pkg::ADDR_W-1:0]     i_key,
    input  logic [nat_pkg::NODE_SLOTS-1:0] i_used,
    input  nat_pkg::t_entry                i_rdata,
    output logic [nat_pkg::IDX_W-1:0]      o_raddr,
    output nat_pkg::t_scan_res             o_res
);

    localparam logic [nat_pkg::CNT_W-1:0] LAST = nat_pkg::CNT_W'(nat_pkg::NODE_SLOTS);

    logic                          r_busy;
    logic [nat_pkg::CNT_W-1:0]     r_idx;
    logic                          r_chk_vld;
    logic [nat_pkg::IDX_W-1:0]     r_chk_idx;
    logic                          r_done;
    logic                          r_hit;
    logic [nat_pkg::IDX_W-1:0]     r_hit_idx;
    logic [nat_pkg::NODE_W-1:0]    r_hit_node;
    logic [nat_pkg::ADDR_W-1:0]    r_hit_addr;
    logic                          r_free;
    logic [nat_pkg::IDX_W-1:0]     r_free_idx;
    logic                          w_used;
    logic                          w_match;

    assign o_raddr = r_idx[nat_pkg::IDX_W-1:0];
    assign w_used  = i_used[r_chk_idx];

    // The address lookup compares the full address, the others the node number.
    always_comb begin
        if (i_op == nat_pkg::OP_NODE_BY_ADDR) begin
            w_match = w_used && (i_rdata.addr == i_key);
        end else begin
            w_match = w_used && (i_rdata.node == i_node);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy    <= 1'b0;
            r_chk_vld <= 1'b0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
            r_idx     <= '0;
        end else if (i_start) begin
            r_busy    <= 1'b1;
            r_idx     <= '0;
            r_chk_vld <= 1'b0;
            r_done    <= 1'b0;
            r_hit     <= 1'b0;
            r_free    <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (r_busy) begin
                if (r_idx != LAST) begin
                    r_chk_vld <= 1'b1;
                    r_chk_idx <= r_idx[nat_pkg::IDX_W-1:0];
                    r_idx     <= r_idx + 1'b1;
                end else begin
                    r_busy    <= 1'b0;
                    r_chk_vld <= 1'b0;
                    r_done    <= 1'b1;
                end
            end
            if (r_chk_vld) begin
                if (w_match && !r_hit) begin
                    r_hit      <= 1'b1;
                    r_hit_idx  <= r_chk_idx;
                    r_hit_node <= i_rdata.node;
                    r_hit_addr <= i_rdata.addr;
                end
                if (!w_used && !r_free) begin
                    r_free     <= 1'b1;
                    r_free_idx <= r_chk_idx;
                end
            end
        end
    end

    always_comb begin
        o_res.done     = r_done;
        o_res.hit      = r_hit;
        o_res.hit_idx  = r_hit_idx;
        o_res.hit_node = r_hit_node;
        o_res.hit_addr = r_hit_addr;
        o_res.free     = r_free;
        o_res.free_idx = r_free_idx;
    end

endmodule

// ----- hw/rtl/node_address_table.sv -----
// Channel   Direction  Valid        Stall         Payload
// input     in         i_in_valid   o_in_stall    i_in_item  (nat_pkg::t_in_item)
// output    out        o_out_valid  i_out_stall   o_out_item (nat_pkg::t_out_item)
// config    in         i_cfg_we     (none)        i_cfg_wdata (broadcast node number)
//
// An item that scans the table reads one slot after another, the scan result is settled,
// the entry is written back in the final state and the block returns to idle before the
// next acceptance. An ignored item skips the scan and goes straight to the final state.
// Reset empties the table at once through per-slot used flags; no clearing pass is needed.
// A result waits in the output register while the output is stalled; the next item is
// still accepted and scanned, and only its write-back waits for that register to drain.
`include "assert_macros.svh"

module node_address_table (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_in_valid,
    output logic                       o_in_stall,
    input  nat_pkg::t_in_item          i_in_item,
    output logic                       o_out_valid,
    input  logic                       i_out_stall,
    output nat_pkg::t_out_item         o_out_item,
    input  logic                       i_cfg_we,
    input  logic [nat_pkg::NODE_W-1:0] i_cfg_wdata
);

    nat_pkg::t_state                  r_state;
    nat_pkg::t_state                  n_state;
    nat_pkg::t_in_item                r_req;
    logic                             r_skip;
    logic [nat_pkg::NODE_W-1:0]       r_bcast;
    logic [nat_pkg::NODE_SLOTS-1:0]   r_used;
    logic [nat_pkg::NODE_SLOTS-1:0]   n_used;
    logic [nat_pkg::CNT_W-1:0]        r_count;
    logic [nat_pkg::CNT_W-1:0]        n_count;
    logic                             r_out_valid;
    nat_pkg::t_out_item               r_out_item;
    nat_pkg::t_out_item               n_out_item;

    logic                             w_accept;
    logic                             w_skip;
    logic                             w_start;
    logic                             w_fin;
    logic                             w_out_free;
    logic                             w_in_stall;
    logic                             w_we;
    logic                             w_set_used;
    logic [nat_pkg::IDX_W-1:0]        w_waddr;
    logic [nat_pkg::IDX_W-1:0]        w_raddr;
    nat_pkg::t_entry                  w_wdata;
    nat_pkg::t_entry                  w_rdata;
    nat_pkg::t_scan_res               w_scan;

    // Handshake. Only one item is in flight; the output register decouples the sides.
    assign w_accept   = i_in_valid && !w_in_stall;
    assign w_out_free = !r_out_valid || !i_out_stall;
    assign o_in_stall = w_in_stall;

    // A remember with an invalid address or the broadcast node, and the unused opcode,
    // change nothing and need no scan.
    assign w_skip = (i_in_item.opcode == nat_pkg::OP_UNUSED) ||
                    ((i_in_item.opcode == nat_pkg::OP_REMEMBER) &&
                     (!i_in_item.key_valid || (i_in_item.node_id == r_bcast)));

    always_comb begin : next_state
        n_state = r_state;
        unique case (r_state)
            nat_pkg::S_IDLE: begin
                if (w_accept) begin
                    n_state = w_skip ? nat_pkg::S_FIN : nat_pkg::S_SCAN;
                end
            end
            nat_pkg::S_SCAN: begin
                if (w_scan.done) begin
                    n_state = nat_pkg::S_FIN;
                end
            end
            nat_pkg::S_FIN: begin
                if (w_out_free) begin
                    n_state = nat_pkg::S_IDLE;
                end
            end
            default: begin
                n_state = nat_pkg::S_IDLE;
            end
        endcase
    end

    always_comb begin : state_outputs
        w_in_stall = (r_state != nat_pkg::S_IDLE);
        w_start    = w_accept && !w_skip;
        w_fin      = (r_state == nat_pkg::S_FIN) && w_out_free;
    end

    // Result and write-back, settled in the final state from the scan outcome.
    always_comb begin : result
        n_out_item        = '0;
        n_out_item.status = nat_pkg::ST_IGNORED;
        w_we              = 1'b0;
        w_set_used        = 1'b0;
        w_waddr           = w_scan.hit_idx;
        n_count           = r_count;
        n_used            = r_used;

        w_wdata.node = r_req.node_id;
        w_wdata.addr = {r_req.key_high, r_req.key_mid, r_req.key_low};
        w_wdata.seen = r_req.now_ms;

        if (!r_skip) begin
            unique case (r_req.opcode)
                nat_pkg::OP_REMEMBER: begin
                    if (w_scan.hit) begin
                        n_out_item.status = nat_pkg::ST_UPDATED;
                        w_we              = w_fin;
                    end else if (w_scan.free) begin
                        n_out_item.status = nat_pkg::ST_INSERTED;
                        w_waddr           = w_scan.free_idx;
                        w_we              = w_fin;
                        w_set_used        = w_fin;
                        n_count           = r_count + 1'b1;
                    end else begin
                        n_out_item.status = nat_pkg::ST_FULL;
                    end
                end
                nat_pkg::OP_ADDR_BY_NODE: begin
                    if (w_scan.hit) begin
                        n_out_item.status        = nat_pkg::ST_HIT;
                        n_out_item.node_out      = r_req.node_id;
                        n_out_item.addr_out_high = w_scan.hit_addr[159:96];
                        n_out_item.addr_out_mid  = w_scan.hit_addr[95:32];
                        n_out_item.addr_out_low  = w_scan.hit_addr[31:0];
                    end else begin
                        n_out_item.status   = nat_pkg::ST_MISS;
                        n_out_item.node_out = r_bcast;
                    end
                end
                nat_pkg::OP_NODE_BY_ADDR: begin
                    if (w_scan.hit) begin
                        n_out_item.status        = nat_pkg::ST_HIT;
                        n_out_item.node_out      = w_scan.hit_node;
                        n_out_item.addr_out_high = r_req.key_high;
                        n_out_item.addr_out_mid  = r_req.key_mid;
                        n_out_item.addr_out_low  = r_req.key_low;
                    end else begin
                        n_out_item.status   = nat_pkg::ST_MISS;
                        n_out_item.node_out = r_bcast;
                    end
                end
                default: begin
                    n_out_item.status = nat_pkg::ST_IGNORED;
                end
            endcase
        end

        if (w_set_used) begin
            n_used[w_waddr] = 1'b1;
        end
        n_out_item.known_count = nat_pkg::COUNT_W'(n_count);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= nat_pkg::S_IDLE;
            r_skip      <= 1'b0;
            r_bcast     <= '1;
            r_used      <= '0;
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                r_bcast <= i_cfg_wdata;
            end
            if (w_accept) begin
                r_skip <= w_skip;
            end
            if (w_fin) begin
                r_used      <= n_used;
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_req <= i_in_item;
        end
        if (w_fin) begin
            r_out_item <= n_out_item;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    // The RAM reads every cycle but its data is used only during the scan, and writes happen
    // only in the final state, so the scan never uses a read that coincides with a write.
    nat_ram #(
        .WIDTH ($bits(nat_pkg::t_entry)),
        .DEPTH (nat_pkg::NODE_SLOTS)
    ) u_slot_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (w_wdata),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    nat_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (w_start),
        .i_op    (r_req.opcode),
        .i_node  (r_req.node_id),
        .i_key   ({r_req.key_high, r_req.key_mid, r_req.key_low}),
        .i_used  (r_used),
        .i_rdata (w_rdata),
        .o_raddr (w_raddr),
        .o_res   (w_scan)
    );

    `NAT_ASSERT(a_count_matches_used, r_count == $countones(r_used), "count out of step")
    `NAT_ASSERT(a_count_in_range, r_count <= nat_pkg::CNT_W'(nat_pkg::NODE_SLOTS), "count too big")
    `NAT_ASSERT_IMP(a_write_only_at_fin, w_we, r_state == nat_pkg::S_FIN, "write outside FIN")
    `NAT_ASSERT_IMP(a_done_only_in_scan, w_scan.done, r_state == nat_pkg::S_SCAN, "done outside scan")

endmodule
